// File: src/dfa_token_scanner_assert.svh
// Assertion macros used by the checker file of the token scanner.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef DFA_TOKEN_SCANNER_ASSERT_SVH
`define DFA_TOKEN_SCANNER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define DTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scanner assertion failed");

// Antecedent implies consequent in the next cycle.
`define DTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scanner assertion failed");

`endif

// File: src/dts_pkg.sv
// Shared types and constants of the token scanner.
// Depends on nothing; used by the top level and by its checker.
package dts_pkg;

    localparam int MAX_TOKEN_LEN_DEFAULT = 255;
    localparam int POSITION_BITS_DEFAULT = 16;

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ID,
        ST_ID_I,
        ST_ID_IN,
        ST_ID_INT,
        ST_LIT,
        ST_GT,
        ST_ONE
    } scan_state_t;

    localparam logic [3:0] KIND_IDENT  = 4'd0;
    localparam logic [3:0] KIND_INTKW  = 4'd1;
    localparam logic [3:0] KIND_LIT    = 4'd2;
    localparam logic [3:0] KIND_GT     = 4'd3;
    localparam logic [3:0] KIND_GE     = 4'd4;
    localparam logic [3:0] KIND_ASSIGN = 4'd5;
    localparam logic [3:0] KIND_PLUS   = 4'd6;
    localparam logic [3:0] KIND_MINUS  = 4'd7;
    localparam logic [3:0] KIND_STAR   = 4'd8;
    localparam logic [3:0] KIND_SLASH  = 4'd9;
    localparam logic [3:0] KIND_SEMI   = 4'd10;
    localparam logic [3:0] KIND_END    = 4'd11;

    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef struct packed {
        logic [7:0] char_code;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] token_start;
        logic [7:0]  token_length;
        logic        last_of_run;
    } out_item_t;

endpackage

// File: src/dfa_token_scanner.sv
// Token scanner usage notes.
// Input channel s_: one character per transfer (char_code, stream_end).
// Result channel m_: one token per transfer (kind, start offset, length,
// last_of_run marking the final result caused by one character).
// A character is scanned in the cycle it is accepted; its zero to three
// results are written into an 8-entry result queue, and m_ shows the oldest
// queued result straight from the queue registers.
// Throughput is one character per cycle while s_ready is high. The result
// queue sets the limit: s_ready is high while at least three entries are
// free, and m_ drains one result per cycle while m_ready is high, so a
// stream end (up to three results) may stall s_ when followed closely by
// more characters. When the receiver stalls, results wait in the queue and
// s_ready drops once fewer than three entries remain free; nothing is lost.
// Synchronous active-low reset on aresetn empties the queue, discards any open
// token and sets the stream offset to zero. After each stream end the scanner
// returns to that scan state by itself; queued results stay in the queue.
// Depends on dts_pkg.
module dfa_token_scanner #(
    parameter int MAX_TOKEN_LEN = dts_pkg::MAX_TOKEN_LEN_DEFAULT,
    parameter int POSITION_BITS = dts_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dts_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dts_pkg::out_item_t  m_data
);
    import dts_pkg::*;

    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);

    scan_state_t               state_reg, state_next;
    logic [3:0]                kind_reg, kind_next;
    logic [POSITION_BITS-1:0]  start_reg, start_next;
    logic [LW-1:0]             len_reg, len_next;
    logic [POSITION_BITS-1:0]  pos_reg, pos_next;

    out_item_t                 q_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]          wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]          count_reg;

    logic                      acc, pop;
    logic [7:0]                c;
    logic                      is_alpha, is_digit, is_alnum;
    logic                      ext;
    scan_state_t               st_ext, st_new, st_after;
    logic [3:0]                kind_ext, kind_new, kind_after;
    logic                      opens;
    logic [LW-1:0]             len_inc;
    logic [POSITION_BITS-1:0]  pos_inc;
    logic                      has_a, has_b;
    out_item_t                 item_a, item_b, item_e;
    out_item_t                 res [3];
    logic [1:0]                n_res;

    function automatic logic [15:0] pos16(input logic [POSITION_BITS-1:0] p);
        logic [POSITION_BITS+15:0] w;
        w = {16'b0, p};
        return w[15:0];
    endfunction

    function automatic logic [7:0] len8(input logic [LW-1:0] l);
        logic [LW+7:0] w;
        w = {8'b0, l};
        return w[7:0];
    endfunction

    assign acc     = s_valid && s_ready;
    assign pop     = m_valid && m_ready;
    assign s_ready = (count_reg <= CNT_W'(FIFO_DEPTH - 3));
    assign m_valid = (count_reg != '0);
    assign m_data  = q_reg[rd_ptr_reg];

    assign c        = s_data.char_code;
    assign is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    assign is_digit = (c >= 8'h30) && (c <= 8'h39);
    assign is_alnum = is_alpha || is_digit;
    assign len_inc  = (len_reg < LW'(MAX_TOKEN_LEN)) ? len_reg + LW'(1) : len_reg;
    assign pos_inc  = pos_reg + POSITION_BITS'(1);

    always_comb begin
        ext      = 1'b0;
        st_ext   = state_reg;
        kind_ext = kind_reg;
        unique case (state_reg)
            ST_IDLE: begin
                ext = 1'b0;
            end
            ST_ID: begin
                ext = is_alnum;
            end
            ST_ID_I: begin
                if (c == CH_N) begin
                    ext    = 1'b1;
                    st_ext = ST_ID_IN;
                end else if (is_alnum) begin
                    ext    = 1'b1;
                    st_ext = ST_ID;
                end
            end
            ST_ID_IN: begin
                if (c == CH_T) begin
                    ext    = 1'b1;
                    st_ext = ST_ID_INT;
                end else if (is_alnum) begin
                    ext    = 1'b1;
                    st_ext = ST_ID;
                end
            end
            ST_ID_INT: begin
                if (is_alnum) begin
                    ext    = 1'b1;
                    st_ext = ST_ID;
                end
            end
            ST_LIT: begin
                ext = is_digit;
            end
            ST_GT: begin
                if (c == CH_EQ) begin
                    ext      = 1'b1;
                    st_ext   = ST_ONE;
                    kind_ext = KIND_GE;
                end
            end
            ST_ONE: begin
                ext = 1'b0;
            end
        endcase

        opens    = 1'b1;
        st_new   = ST_ONE;
        kind_new = KIND_IDENT;
        if (is_alpha) begin
            st_new = (c == CH_I) ? ST_ID_I : ST_ID;
        end else if (is_digit) begin
            st_new   = ST_LIT;
            kind_new = KIND_LIT;
        end else if (c == CH_GT) begin
            st_new   = ST_GT;
            kind_new = KIND_GT;
        end else if (c == CH_EQ) begin
            kind_new = KIND_ASSIGN;
        end else if (c == CH_PLUS) begin
            kind_new = KIND_PLUS;
        end else if (c == CH_MINUS) begin
            kind_new = KIND_MINUS;
        end else if (c == CH_STAR) begin
            kind_new = KIND_STAR;
        end else if (c == CH_SLASH) begin
            kind_new = KIND_SLASH;
        end else if (c == CH_SEMI) begin
            kind_new = KIND_SEMI;
        end else begin
            opens  = 1'b0;
            st_new = ST_IDLE;
        end

        has_a = !ext && (state_reg != ST_IDLE);
        item_a.token_kind   = (state_reg == ST_ID_INT) ? KIND_INTKW : kind_reg;
        item_a.token_start  = pos16(start_reg);
        item_a.token_length = len8(len_reg);
        item_a.last_of_run  = 1'b0;

        if (ext) begin
            st_after   = st_ext;
            kind_after = kind_ext;
            start_next = start_reg;
            len_next   = len_inc;
        end else if (opens) begin
            st_after   = st_new;
            kind_after = kind_new;
            start_next = pos_reg;
            len_next   = LW'(1);
        end else begin
            st_after   = ST_IDLE;
            kind_after = kind_reg;
            start_next = start_reg;
            len_next   = len_reg;
        end

        has_b = s_data.stream_end && (st_after != ST_IDLE);
        item_b.token_kind   = (st_after == ST_ID_INT) ? KIND_INTKW : kind_after;
        item_b.token_start  = pos16(start_next);
        item_b.token_length = len8(len_next);
        item_b.last_of_run  = 1'b0;

        item_e.token_kind   = KIND_END;
        item_e.token_start  = pos16(pos_inc);
        item_e.token_length = 8'd0;
        item_e.last_of_run  = 1'b0;

        res[2] = item_e;
        if (has_a) begin
            res[0] = item_a;
            res[1] = has_b ? item_b : item_e;
        end else begin
            res[0] = has_b ? item_b : item_e;
            res[1] = item_e;
        end
        n_res = 2'(has_a) + 2'(has_b) + 2'(s_data.stream_end);
        res[0].last_of_run = (n_res == 2'd1);
        res[1].last_of_run = (n_res == 2'd2);
        res[2].last_of_run = (n_res == 2'd3);

        if (s_data.stream_end) begin
            state_next = ST_IDLE;
            kind_next  = KIND_IDENT;
            start_next = '0;
            len_next   = '0;
            pos_next   = '0;
        end else begin
            state_next = st_after;
            kind_next  = kind_after;
            pos_next   = pos_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_IDENT;
            start_reg <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
        end else if (acc) begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < n_res) begin
                    q_reg[wr_ptr_reg + PTR_W'(k)] <= res[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (acc) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_res);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + (acc ? CNT_W'(n_res) : CNT_W'(0))
                         - (pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

endmodule

// File: src/dfa_token_scanner_checker.sv
// Port-level checker for the token scanner, bound to every instance of it.
// Depends on dts_pkg and on the macros in dfa_token_scanner_assert.svh.
`include "dfa_token_scanner_assert.svh"

module dfa_token_scanner_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input dts_pkg::in_item_t   s_data,
    input logic                m_valid,
    input logic                m_ready,
    input dts_pkg::out_item_t  m_data
);
    import dts_pkg::*;

    // A stalled result transfer keeps its contents.
    `DTS_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // The end marker has no length and always closes the run of its character.
    `DTS_ASSERT_SAME(a_end, aclk, aresetn, m_valid && (m_data.token_kind == KIND_END), (m_data.token_length == 8'd0) && m_data.last_of_run)

    // A greater-equal token is always two characters long.
    `DTS_ASSERT_SAME(a_ge_len, aclk, aresetn, m_valid && (m_data.token_kind == KIND_GE), m_data.token_length == 8'd2)

    // No kind code beyond the end marker is ever produced.
    `DTS_ASSERT_SAME(a_kind, aclk, aresetn, m_valid, m_data.token_kind <= KIND_END)

endmodule

bind dfa_token_scanner dfa_token_scanner_checker u_checker (.*);

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of dfa_token_scanner: random and directed character streams,
// each accepted character predicted into expected tokens that the result monitor checks.
// Depends on dts_pkg and dfa_token_scanner.
module tb_top;
    import dts_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_CHARS  = 320;
    localparam int TAIL_CHARS    = 20;
    localparam int HOLD_AT       = 60;
    localparam int HOLD_CYCLES   = 120;
    localparam int CALM_FROM     = 150;
    localparam int CALM_TO       = 250;
    localparam int SETTLE_CYCLES = 20;

    localparam logic [47:0] OP_CHARS = {CH_EQ, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_SEMI};
    localparam logic [23:0] KW_CHARS = {CH_I, CH_N, CH_T};

    typedef struct {
        in_item_t item;
        bit       wait_drain;
    } char_entry_t;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    char_entry_t pending_chars[$];
    out_item_t   expected_tokens[$];

    scan_state_t scan_st;
    logic [3:0]  open_kind;
    logic [15:0] open_start;
    logic [7:0]  open_len;
    logic [15:0] char_pos;

    int accepted_chars = 0;
    int result_count   = 0;
    int mismatch_count = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int cycle_count    = 0;

    dfa_token_scanner uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < 100) begin
            $display("result %0d: %s", result_count, what);
        end
        mismatch_count++;
    endtask

    function automatic bit quiet_phase();
        return accepted_chars >= CALM_FROM && accepted_chars < CALM_TO;
    endfunction

    task automatic append_expected(input out_item_t tok);
        expected_tokens.insert(expected_tokens.size(), tok);
    endtask

    task automatic clear_scan_state();
        scan_st    = ST_IDLE;
        open_kind  = '0;
        open_start = '0;
        open_len   = '0;
        char_pos   = '0;
    endtask

    task automatic close_open_token();
        out_item_t tok;
        if (scan_st != ST_IDLE) begin
            tok.token_kind   = (scan_st == ST_ID_INT) ? KIND_INTKW : open_kind;
            tok.token_start  = open_start;
            tok.token_length = open_len;
            tok.last_of_run  = 1'b0;
            append_expected(tok);
        end
        scan_st = ST_IDLE;
    endtask

    task automatic predict_tokens(input in_item_t it);
        logic [7:0] c;
        logic       is_alpha;
        logic       is_digit;
        logic       is_alnum;
        logic       grows;
        logic [3:0] kind;
        int         queued;
        out_item_t  tok;
        c        = it.char_code;
        queued   = expected_tokens.size();
        is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        is_digit = c >= "0" && c <= "9";
        is_alnum = is_alpha || is_digit;
        grows    = 1'b0;
        case (scan_st)
            ST_ID: grows = is_alnum;
            ST_ID_I: begin
                if (c == CH_N) scan_st = ST_ID_IN;
                else if (is_alnum) scan_st = ST_ID;
                grows = is_alnum;
            end
            ST_ID_IN: begin
                if (c == CH_T) scan_st = ST_ID_INT;
                else if (is_alnum) scan_st = ST_ID;
                grows = is_alnum;
            end
            ST_ID_INT: begin
                if (is_alnum) scan_st = ST_ID;
                grows = is_alnum;
            end
            ST_LIT: grows = is_digit;
            ST_GT: begin
                if (c == CH_EQ) begin
                    scan_st   = ST_ONE;
                    open_kind = KIND_GE;
                    grows     = 1'b1;
                end
            end
            default: grows = 1'b0;
        endcase

        if (grows) begin
            if (open_len < MAX_TOKEN_LEN_DEFAULT) open_len = open_len + 1'b1;
        end else begin
            close_open_token();
            kind    = KIND_IDENT;
            scan_st = ST_ONE;
            if (is_alpha) begin
                if (c == CH_I) scan_st = ST_ID_I;
                else scan_st = ST_ID;
            end else if (is_digit) begin
                scan_st = ST_LIT;
                kind    = KIND_LIT;
            end else begin
                case (c)
                    CH_GT: begin
                        scan_st = ST_GT;
                        kind    = KIND_GT;
                    end
                    CH_EQ:    kind = KIND_ASSIGN;
                    CH_PLUS:  kind = KIND_PLUS;
                    CH_MINUS: kind = KIND_MINUS;
                    CH_STAR:  kind = KIND_STAR;
                    CH_SLASH: kind = KIND_SLASH;
                    CH_SEMI:  kind = KIND_SEMI;
                    default:  scan_st = ST_IDLE;
                endcase
            end
            if (scan_st != ST_IDLE) begin
                open_kind  = kind;
                open_start = char_pos;
                open_len   = 8'd1;
            end
        end
        char_pos = char_pos + 1'b1;

        if (it.stream_end) begin
            close_open_token();
            tok.token_kind   = KIND_END;
            tok.token_start  = char_pos;
            tok.token_length = 8'd0;
            tok.last_of_run  = 1'b0;
            append_expected(tok);
            clear_scan_state();
        end
        if (expected_tokens.size() > queued) begin
            tok = expected_tokens.pop_back();
            tok.last_of_run = 1'b1;
            append_expected(tok);
        end
    endtask

    task automatic push_char(input logic [7:0] c, input bit last, input bit drain);
        char_entry_t e;
        e.item.char_code  = c;
        e.item.stream_end = last;
        e.wait_drain      = drain;
        pending_chars.insert(pending_chars.size(), e);
    endtask

    task automatic push_text(input string s, input bit end_stream);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i], end_stream && (i == s.len() - 1), 1'b0);
        end
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] off;
        off = 8'($urandom_range(0, 25));
        return ($urandom_range(0, 1) != 0) ? ("a" + off) : ("A" + off);
    endfunction

    function automatic logic [7:0] rand_digit();
        logic [7:0] off;
        off = 8'($urandom_range(0, 9));
        return "0" + off;
    endfunction

    function automatic logic [7:0] rand_alnum();
        return ($urandom_range(0, 61) < 10) ? rand_digit() : rand_letter();
    endfunction

    // Mostly well-formed tokens with random content; a sixth of the picks are raw bytes.
    task automatic push_random_token();
        int unsigned len;
        int unsigned n;
        logic [7:0]  b;
        char_entry_t e;
        string       seps;
        seps = " ()\t\n";
        case ($urandom_range(0, 11))
            0, 1, 2: begin
                len = ($urandom_range(0, 39) == 0) ? $urandom_range(256, 300)
                                                   : $urandom_range(1, 8);
                push_char(rand_letter(), 1'b0, 1'b0);
                for (int i = 1; i < len; i++) push_char(rand_alnum(), 1'b0, 1'b0);
            end
            3: begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) push_char(KW_CHARS[23 - 8 * i -: 8], 1'b0, 1'b0);
                if ($urandom_range(0, 2) == 0) push_char(rand_alnum(), 1'b0, 1'b0);
            end
            4: begin
                len = ($urandom_range(0, 39) == 0) ? $urandom_range(256, 300)
                                                   : $urandom_range(1, 6);
                for (int i = 0; i < len; i++) push_char(rand_digit(), 1'b0, 1'b0);
            end
            5: begin
                push_char(CH_GT, 1'b0, 1'b0);
                if ($urandom_range(0, 1) != 0) push_char(CH_EQ, 1'b0, 1'b0);
            end
            6, 7: begin
                n = $urandom_range(0, 5);
                push_char(OP_CHARS[8 * n +: 8], 1'b0, 1'b0);
            end
            8, 9: begin
                n = $urandom_range(0, seps.len() - 1);
                push_char(seps[n], 1'b0, 1'b0);
            end
            10: begin
                b = 8'($urandom_range(128, 255));
                push_char(b, 1'b0, 1'b0);
            end
            default: begin
                b = 8'($urandom_range(0, 255));
                push_char(b, 1'b0, 1'b0);
            end
        endcase
        if ($urandom_range(0, 11) == 0) begin
            e = pending_chars.pop_back();
            e.item.stream_end = 1'b1;
            pending_chars.insert(pending_chars.size(), e);
        end
    endtask

    always @(posedge aclk) begin : char_driver
        char_entry_t next_char;
        bit          gap;
        if (!aresetn) begin
            s_valid <= 1'b0;
            clear_scan_state();
        end else begin
            if (s_valid && s_ready) begin
                predict_tokens(s_data);
                accepted_chars <= accepted_chars + 1;
            end
            if (!s_valid || s_ready) begin
                gap = (hold_left == 0) && !quiet_phase() && ($urandom_range(0, 99) < 25);
                if (pending_chars.size() != 0 && !gap
                        && !(pending_chars[0].wait_drain && expected_tokens.size() != 0)) begin
                    next_char = pending_chars.pop_front();
                    s_data  <= next_char.item;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // The receiver holds off once for a long stretch so the result queue fills.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && accepted_chars == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin : token_monitor
        out_item_t oldest;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch($sformatf("unexpected token kind %0d start %0d length %0d",
                        m_data.token_kind, m_data.token_start, m_data.token_length));
                end else begin
                    oldest = expected_tokens.pop_front();
                    if (m_data.token_kind !== oldest.token_kind)
                        report_mismatch($sformatf("token_kind %0d, expected %0d",
                            m_data.token_kind, oldest.token_kind));
                    if (m_data.token_start !== oldest.token_start)
                        report_mismatch($sformatf("token_start %0d, expected %0d",
                            m_data.token_start, oldest.token_start));
                    if (m_data.token_length !== oldest.token_length)
                        report_mismatch($sformatf("token_length %0d, expected %0d",
                            m_data.token_length, oldest.token_length));
                    if (m_data.last_of_run !== oldest.last_of_run)
                        report_mismatch($sformatf("last_of_run %0d, expected %0d",
                            m_data.last_of_run, oldest.last_of_run));
                end
                result_count++;
            end
            m_ready <= (hold_left == 0) && (quiet_phase() || $urandom_range(0, 99) >= 25);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int random_goal;
        push_text("int int0 12ab>==>+-*/;", 1'b0);
        push_text("int", 1'b1);
        push_text("z;", 1'b1);
        push_char(8'h00, 1'b1, 1'b0);

        random_goal = pending_chars.size() + RANDOM_CHARS;
        while (pending_chars.size() < random_goal) push_random_token();

        // One last stream, sent only after every earlier result has been drained.
        push_char(rand_letter(), 1'b0, 1'b1);
        for (int i = 0; i < TAIL_CHARS; i++) push_char(rand_alnum(), 1'b0, 1'b0);
        push_text(";Z", 1'b1);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_chars.size() != 0 || s_valid || expected_tokens.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_tokens.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/dts_pkg.sv
src/dfa_token_scanner.sv
src/dfa_token_scanner_checker.sv
tb/sv/tb_top.sv
